// ===== design/motion_load_and_sprint_detector_assert.svh =====
`ifndef MOTION_LOAD_AND_SPRINT_DETECTOR_ASSERT_SVH
`define MOTION_LOAD_AND_SPRINT_DETECTOR_ASSERT_SVH
// implication check under reset
`define MLSD_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// next-cycle implication check under reset
`define MLSD_ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

// ===== design/mlsd_pkg.sv =====
package mlsd_pkg;
   localparam int CFG_IDX_BITS = 3;
   localparam logic [CFG_IDX_BITS-1:0] REG_IMPACT = 3'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL  = 3'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_SCALE  = 3'd2;
   localparam logic [CFG_IDX_BITS-1:0] REG_GPS    = 3'd3;
   localparam logic [CFG_IDX_BITS-1:0] REG_SUSTAIN = 3'd4;
   localparam logic [CFG_IDX_BITS-1:0] REG_COOL   = 3'd5;
   localparam int ROOT_IN_BITS = 52;
   localparam int ROOT_BITS = 26;

   typedef enum logic [2:0] {
      BK_IDLE, BK_ROOT1, BK_ROOT2, BK_MUL, BK_ACC, BK_OUT
   } back_state_type;
endpackage

// ===== design/motion_load_and_sprint_detector.sv =====
// Motion load and sprint detector. One result per sample; each item passes
// twice through the shared bit-serial square root (magnitude, then change
// magnitude) in the back end; a clear item skips both. A two-entry queue
// decouples input acceptance from processing.
module motion_load_and_sprint_detector import mlsd_pkg::*; #(
   parameter int ACCEL_BITS = 16,
   parameter int LOAD_BITS = 48,
   parameter int COUNT_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [ACCEL_BITS-1:0] req_accel_x,
   input  logic signed [ACCEL_BITS-1:0] req_accel_y,
   input  logic signed [ACCEL_BITS-1:0] req_accel_z,
   input  logic [31:0] req_time_ms,
   input  logic [15:0] req_gps_speed,
   input  logic req_clear_metrics,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [15:0] rsp_magnitude,
   output logic [15:0] rsp_peak_impact,
   output logic [LOAD_BITS-1:0] rsp_load_total,
   output logic [COUNT_BITS-1:0] rsp_sprint_total,
   output logic rsp_sprinting,
   output logic rsp_sprint_started,
   output logic rsp_in_cooldown,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CFG_IDX_BITS-1:0] csr_index,
   input  logic [15:0] csr_data
);
   logic [15:0] imp_ff, acc_ff, scl_ff, gps_ff, sus_ff, cool_ff;
   logic q_pop, q_valid;
   logic [3*ACCEL_BITS+48:0] q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         imp_ff <= 16'd16384; acc_ff <= 16'd4096; scl_ff <= 16'd256;
         gps_ff <= 16'd550; sus_ff <= 16'd300; cool_ff <= 16'd2000;
      end else if (csr_valid) begin
         case (csr_index)
            REG_IMPACT:  imp_ff <= csr_data;
            REG_ACCEL:   acc_ff <= csr_data;
            REG_SCALE:   scl_ff <= csr_data;
            REG_GPS:     gps_ff <= csr_data;
            REG_SUSTAIN: sus_ff <= csr_data;
            REG_COOL:    cool_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mlsd_front #(.ACCEL_BITS(ACCEL_BITS)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_accel_x(req_accel_x), .req_accel_y(req_accel_y), .req_accel_z(req_accel_z),
      .req_time_ms(req_time_ms), .req_gps_speed(req_gps_speed),
      .req_clear_metrics(req_clear_metrics),
      .q_pop(q_pop), .q_valid(q_valid), .q_data(q_data));

   mlsd_back #(.ACCEL_BITS(ACCEL_BITS), .LOAD_BITS(LOAD_BITS), .COUNT_BITS(COUNT_BITS))
   u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
      .cfg_impact(imp_ff), .cfg_accel(acc_ff), .cfg_scale(scl_ff), .cfg_gps(gps_ff),
      .cfg_sustain(sus_ff), .cfg_cool(cool_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_magnitude(rsp_magnitude),
      .rsp_peak_impact(rsp_peak_impact), .rsp_load_total(rsp_load_total),
      .rsp_sprint_total(rsp_sprint_total), .rsp_sprinting(rsp_sprinting),
      .rsp_sprint_started(rsp_sprint_started), .rsp_in_cooldown(rsp_in_cooldown));
endmodule

// ===== design/mlsd_root.sv =====
module mlsd_root import mlsd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [ROOT_IN_BITS-1:0] value,
   output logic                    done,
   output logic [ROOT_BITS-1:0]    root
);
   localparam int CNT_BITS = $clog2(ROOT_BITS + 1);
   logic [ROOT_IN_BITS-1:0] rem_ff, rem_in, sh_ff, sh_in;
   logic [ROOT_BITS-1:0] q_ff, q_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_in, done_ff;
   logic [ROOT_BITS+1:0] trial, cur;

   always_comb begin
      rem_in = rem_ff;
      sh_in = sh_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cur = {rem_ff[ROOT_BITS-1:0], sh_ff[ROOT_IN_BITS-1 -: 2]};
      trial = {q_ff, 2'b01};
      if (start) begin
         rem_in = '0;
         sh_in = value;
         q_in = '0;
         cnt_in = CNT_BITS'(ROOT_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in = {sh_ff[ROOT_IN_BITS-3:0], 2'b00};
         if (cur >= trial) begin
            rem_in = ROOT_IN_BITS'(cur - trial);
            q_in = {q_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in = ROOT_IN_BITS'(cur);
            q_in = {q_ff[ROOT_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff <= sh_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = q_ff;
endmodule

// ===== design/mlsd_front.sv =====
module mlsd_front import mlsd_pkg::*; #(
   parameter int ACCEL_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [ACCEL_BITS-1:0] req_accel_x,
   input  logic signed [ACCEL_BITS-1:0] req_accel_y,
   input  logic signed [ACCEL_BITS-1:0] req_accel_z,
   input  logic [31:0]            req_time_ms,
   input  logic [15:0]            req_gps_speed,
   input  logic                   req_clear_metrics,
   input  logic                   q_pop,
   output logic                   q_valid,
   output logic [3*ACCEL_BITS+49-1:0] q_data
);
   localparam int W = 3*ACCEL_BITS + 49;
   logic [W-1:0] slot_ff [2];
   logic [1:0] full_ff, full_in;
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic push;

   assign req_stall = full_ff[wp_ff];
   assign push = req_valid && !req_stall;
   assign q_valid = full_ff[rp_ff];
   assign q_data = slot_ff[rp_ff];

   always_comb begin
      full_in = full_ff;
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (q_pop && q_valid) begin
         full_in[rp_ff] = 1'b0;
         rp_in = ~rp_ff;
      end
      if (push) begin
         full_in[wp_ff] = 1'b1;
         wp_in = ~wp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wp_ff] <= {req_accel_x, req_accel_y, req_accel_z, req_time_ms,
                            req_gps_speed, req_clear_metrics};
      if (reset) begin
         full_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end
endmodule

// ===== design/mlsd_back.sv =====
module mlsd_back import mlsd_pkg::*; #(
   parameter int ACCEL_BITS = 16,
   parameter int LOAD_BITS = 48,
   parameter int COUNT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  logic [3*ACCEL_BITS+49-1:0] q_data,
   output logic                      q_pop,
   input  logic [15:0]               cfg_impact,
   input  logic [15:0]               cfg_accel,
   input  logic [15:0]               cfg_scale,
   input  logic [15:0]               cfg_gps,
   input  logic [15:0]               cfg_sustain,
   input  logic [15:0]               cfg_cool,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [15:0]               rsp_magnitude,
   output logic [15:0]               rsp_peak_impact,
   output logic [LOAD_BITS-1:0]      rsp_load_total,
   output logic [COUNT_BITS-1:0]     rsp_sprint_total,
   output logic                      rsp_sprinting,
   output logic                      rsp_sprint_started,
   output logic                      rsp_in_cooldown
);
   localparam int A = ACCEL_BITS;
   localparam int D = ACCEL_BITS + 1;
   localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   back_state_type st_ff, st_in;
   logic signed [A-1:0] x_ff, y_ff, z_ff, px_ff, py_ff, pz_ff;
   logic [31:0] now_ff;
   logic [15:0] spd_ff;
   logic clr_ff;
   logic [ROOT_BITS-1:0] mag_ff;
   logic [ROOT_BITS+15:0] prod_ff;
   logic [15:0] peak_ff;
   logic [LOAD_BITS-1:0] load_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic sa_ff, ca_ff, started_ff, cool_ff;
   logic [31:0] cstart_ff, lfin_ff;
   logic rsp_valid_ff;

   logic rt_start, rt_done;
   logic [ROOT_IN_BITS-1:0] rt_value;
   logic [ROOT_BITS-1:0] rt_root;
   logic signed [D-1:0] dx, dy, dz;
   logic [D-1:0] ux, uy, uz;
   logic [2*D-1:0] sq_x, sq_y, sq_z;
   logic [ROOT_IN_BITS-1:0] sum_sq;
   logic [ROOT_BITS+15:0] inc;
   logic [LOAD_BITS+ROOT_BITS+15:0] inc_w, head;
   logic prev_nz;

   mlsd_root u_root (.clock(clock), .reset(reset), .start(rt_start), .value(rt_value),
                     .done(rt_done), .root(rt_root));

   always_comb begin
      if (st_ff == BK_ROOT1) begin
         dx = D'(x_ff);
         dy = D'(y_ff);
         dz = D'(z_ff);
      end else begin
         dx = D'(x_ff) - D'(px_ff);
         dy = D'(y_ff) - D'(py_ff);
         dz = D'(z_ff) - D'(pz_ff);
      end
      ux = dx[D-1] ? D'(-dx) : D'(dx);
      uy = dy[D-1] ? D'(-dy) : D'(dy);
      uz = dz[D-1] ? D'(-dz) : D'(dz);
      sq_x = ux * ux;
      sq_y = uy * uy;
      sq_z = uz * uz;
      sum_sq = ROOT_IN_BITS'(sq_x) + ROOT_IN_BITS'(sq_y) + ROOT_IN_BITS'(sq_z);
      rt_value = sum_sq;
   end

   assign prev_nz = (px_ff != '0) || (py_ff != '0) || (pz_ff != '0);
   assign inc = prod_ff >> 8;
   assign inc_w = (LOAD_BITS+ROOT_BITS+16)'(load_ff) + (LOAD_BITS+ROOT_BITS+16)'(inc);
   assign head = inc_w >> LOAD_BITS;
   assign q_pop = (st_ff == BK_IDLE) && q_valid;

   logic [A-1:0] ax_abs_n;
   logic [A:0] ax_abs;
   assign ax_abs_n = x_ff[A-1] ? A'(-x_ff) : A'(x_ff);
   assign ax_abs = (x_ff[A-1] && ax_abs_n == '0) ? {1'b1, {A{1'b0}}} : {1'b0, ax_abs_n};

   always_comb begin
      st_in = st_ff;
      rt_start = 1'b0;
      case (st_ff)
         BK_IDLE:  if (q_valid) st_in = BK_ROOT1;
         BK_ROOT1: begin
            if (clr_ff) st_in = BK_OUT;
            else begin
               rt_start = 1'b1;
               st_in = BK_ROOT2;
            end
         end
         BK_ROOT2: if (rt_done) begin
            st_in = BK_MUL;
            rt_start = 1'b1;
         end
         BK_MUL:   if (rt_done) st_in = BK_ACC;
         BK_ACC:   st_in = BK_OUT;
         BK_OUT:   if (!rsp_valid_ff || !rsp_stall) st_in = BK_IDLE;
         default:  st_in = BK_IDLE;
      endcase
   end

   logic [31:0] tcool, tcand;
   logic gps_fast, ca_n, imu_fast, now_sprint, in_cool, sprint_end;
   assign tcool = now_ff - lfin_ff;
   assign in_cool = tcool < 32'(cfg_cool);
   assign gps_fast = spd_ff > cfg_gps;
   assign ca_n = ax_abs > (A+1)'(cfg_accel);
   assign tcand = now_ff - (ca_ff ? cstart_ff : now_ff);
   assign imu_fast = ca_n && (tcand >= 32'(cfg_sustain));
   assign now_sprint = gps_fast || imu_fast;
   assign sprint_end = !now_sprint && sa_ff;

   always_ff @(posedge clock) begin
      if (st_ff == BK_IDLE && q_valid) begin
         x_ff <= q_data[3*A+48 -: A];
         y_ff <= q_data[2*A+48 -: A];
         z_ff <= q_data[A+48 -: A];
         now_ff <= q_data[48:17];
         spd_ff <= q_data[16:1];
         clr_ff <= q_data[0];
      end
      if (st_ff == BK_ROOT2 && rt_done) mag_ff <= rt_root;
      if (st_ff == BK_MUL && rt_done) prod_ff <= rt_root * cfg_scale;
      if (reset) begin
         st_ff <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         px_ff <= '0; py_ff <= '0; pz_ff <= '0;
         peak_ff <= '0; load_ff <= '0; cnt_ff <= '0;
         sa_ff <= 1'b0; ca_ff <= 1'b0; cstart_ff <= '0; lfin_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == BK_ROOT1 && clr_ff) begin
            load_ff <= '0; peak_ff <= '0; cnt_ff <= '0;
            mag_ff <= '0;
            started_ff <= 1'b0; cool_ff <= 1'b0;
         end
         if (st_ff == BK_ACC) begin
            if (mag_ff > ROOT_BITS'(cfg_impact) && mag_ff > ROOT_BITS'(peak_ff))
               peak_ff <= 16'(mag_ff);
            if (prev_nz) load_ff <= (head != '0) ? LOAD_MAX : LOAD_BITS'(inc_w);
            px_ff <= x_ff; py_ff <= y_ff; pz_ff <= z_ff;
            started_ff <= !in_cool && now_sprint && !sa_ff;
            cool_ff <= in_cool;
            if (in_cool) begin
               sa_ff <= 1'b0; ca_ff <= 1'b0;
            end else begin
               ca_ff <= ca_n && !sprint_end;
               if (ca_n && !ca_ff) cstart_ff <= now_ff;
               if (now_sprint && !sa_ff) begin
                  if (cnt_ff != COUNT_MAX) cnt_ff <= cnt_ff + 1'b1;
                  sa_ff <= 1'b1;
               end else if (sprint_end) begin
                  sa_ff <= 1'b0; lfin_ff <= now_ff;
               end
            end
         end
         if (st_ff == BK_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
            rsp_magnitude <= 16'(mag_ff);
            rsp_peak_impact <= peak_ff;
            rsp_load_total <= load_ff;
            rsp_sprint_total <= cnt_ff;
            rsp_sprinting <= sa_ff;
            rsp_sprint_started <= started_ff;
            rsp_in_cooldown <= cool_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== design/mlsd_checker.sv =====
`include "motion_load_and_sprint_detector_assert.svh"
module mlsd_checker #(
   parameter int COUNT_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_sprinting,
   input logic rsp_sprint_started,
   input logic rsp_in_cooldown,
   input logic [COUNT_BITS-1:0] rsp_sprint_total
);
   `MLSD_ASSERT_IMP(started_implies_sprinting, clock, reset,
      rsp_valid && rsp_sprint_started, rsp_sprinting)
   `MLSD_ASSERT_IMP(cooldown_not_sprinting, clock, reset,
      rsp_valid && rsp_in_cooldown, !rsp_sprinting && !rsp_sprint_started)
   `MLSD_ASSERT_NXT(rsp_held_on_stall, clock, reset,
      rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sprint_total))
endmodule

bind motion_load_and_sprint_detector mlsd_checker #(.COUNT_BITS(COUNT_BITS)) u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_sprinting(rsp_sprinting), .rsp_sprint_started(rsp_sprint_started),
   .rsp_in_cooldown(rsp_in_cooldown), .rsp_sprint_total(rsp_sprint_total));
